[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle implication check failed.");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle implication check failed.");

`endif

[rtl/rvd_pkg.sv]
// ----------------------------------------------------------------------------
// RV32I decoder package
// Format classes, operation numbers and the decode result structure.
// ----------------------------------------------------------------------------
package rvd_pkg;

   // Instruction format class.
   typedef enum logic [2:0] {
      FMT_R       = 3'd0,
      FMT_I       = 3'd1,
      FMT_S       = 3'd2,
      FMT_B       = 3'd3,
      FMT_U       = 3'd4,
      FMT_J       = 3'd5,
      FMT_UNKNOWN = 3'd6
   } fmt_type;

   // Dense operation number; the values follow the listed order.
   typedef enum logic [5:0] {
      OP_UNKNOWN = 6'd0,
      OP_BAD_LOAD, OP_BAD_STORE, OP_BAD_BRANCH,
      OP_SUB, OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRA, OP_SRL,
      OP_OR, OP_AND,
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
      OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRAI, OP_SRLI,
      OP_ORI, OP_ANDI, OP_JALR, OP_ECALL, OP_EBREAK,
      OP_SB, OP_SH, OP_SW,
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
      OP_LUI, OP_AUIPC, OP_JAL
   } op_type;

   // Complete decode of one instruction word.
   typedef struct packed {
      logic [6:0]         major_opcode;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic [2:0]         func3_field;
      logic [6:0]         func7_field;
      fmt_type            format_class;
      logic signed [31:0] immediate;
      op_type             operation;
   } dec_result_type;

endpackage

[rtl/rvd_channels.sv]
// ----------------------------------------------------------------------------
// Decoder channels
// Valid/ready interfaces for instruction requests and decode responses.
// ----------------------------------------------------------------------------

// Request channel: one instruction word per transaction.
interface rvd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

// Response channel: one decoded instruction per transaction.
interface rvd_rsp_if;
   logic               valid;
   logic               ready;
   logic [6:0]         major_opcode;
   logic [4:0]         dest_reg;
   logic [4:0]         src1_reg;
   logic [4:0]         src2_reg;
   logic [2:0]         func3_field;
   logic [6:0]         func7_field;
   logic [2:0]         format_class;
   logic signed [31:0] immediate;
   logic [5:0]         operation;

   modport source (output valid, output major_opcode, output dest_reg,
                   output src1_reg, output src2_reg, output func3_field,
                   output func7_field, output format_class, output immediate,
                   output operation, input ready);
   modport sink   (input valid, input major_opcode, input dest_reg,
                   input src1_reg, input src2_reg, input func3_field,
                   input func7_field, input format_class, input immediate,
                   input operation, output ready);
endinterface

[rtl/rvd_decode.sv]
// ----------------------------------------------------------------------------
// RV32I field decoder
// Combinational split of an instruction word into fields, format class,
// immediate and operation number.
// ----------------------------------------------------------------------------
module rvd_decode
   import rvd_pkg::*;
(
   input  logic [31:0]    instr_word,
   output dec_result_type result
);

   // Major opcodes of RV32I.
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] FUNCT7_ALT = 7'h20;

   localparam logic [2:0] F3_SL  = 3'd1;
   localparam logic [2:0] F3_SR  = 3'd5;

   // Register-register operation by funct3, with the alternate encodings.
   function automatic op_type r_op(input logic [2:0] f3, input logic alt);
      op_type op;
      case (f3)
         3'd0:    op = alt ? OP_SUB : OP_ADD;
         3'd1:    op = OP_SLL;
         3'd2:    op = OP_SLT;
         3'd3:    op = OP_SLTU;
         3'd4:    op = OP_XOR;
         3'd5:    op = alt ? OP_SRA : OP_SRL;
         3'd6:    op = OP_OR;
         default: op = OP_AND;
      endcase
      return op;
   endfunction

   function automatic op_type load_op(input logic [2:0] f3);
      op_type op;
      case (f3)
         3'd0:    op = OP_LB;
         3'd1:    op = OP_LH;
         3'd2:    op = OP_LW;
         3'd4:    op = OP_LBU;
         3'd5:    op = OP_LHU;
         default: op = OP_BAD_LOAD;
      endcase
      return op;
   endfunction

   function automatic op_type alui_op(input logic [2:0] f3, input logic alt);
      op_type op;
      case (f3)
         3'd0:    op = OP_ADDI;
         3'd1:    op = OP_SLLI;
         3'd2:    op = OP_SLTI;
         3'd3:    op = OP_SLTIU;
         3'd4:    op = OP_XORI;
         3'd5:    op = alt ? OP_SRAI : OP_SRLI;
         3'd6:    op = OP_ORI;
         default: op = OP_ANDI;
      endcase
      return op;
   endfunction

   function automatic op_type store_op(input logic [2:0] f3);
      op_type op;
      case (f3)
         3'd0:    op = OP_SB;
         3'd1:    op = OP_SH;
         3'd2:    op = OP_SW;
         default: op = OP_BAD_STORE;
      endcase
      return op;
   endfunction

   function automatic op_type branch_op(input logic [2:0] f3);
      op_type op;
      case (f3)
         3'd0:    op = OP_BEQ;
         3'd1:    op = OP_BNE;
         3'd4:    op = OP_BLT;
         3'd5:    op = OP_BGE;
         3'd6:    op = OP_BLTU;
         3'd7:    op = OP_BGEU;
         default: op = OP_BAD_BRANCH;
      endcase
      return op;
   endfunction

   logic [6:0]  opc;
   logic [2:0]  f3;
   logic        alt;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   logic [31:0] shamt;

   // Fixed fields and the candidate immediates of every format.
   assign opc   = instr_word[6:0];
   assign f3    = instr_word[14:12];
   assign alt   = (instr_word[31:25] == FUNCT7_ALT);
   assign imm_i = {{20{instr_word[31]}}, instr_word[31:20]};
   assign imm_s = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
   assign imm_b = {{19{instr_word[31]}}, instr_word[31], instr_word[7],
                   instr_word[30:25], instr_word[11:8], 1'b0};
   assign imm_u = {instr_word[31:12], 12'b0};
   assign imm_j = {{11{instr_word[31]}}, instr_word[31], instr_word[19:12],
                   instr_word[20], instr_word[30:21], 1'b0};
   assign shamt = {27'b0, instr_word[24:20]};

   // Opcode classification and operation selection.
   always_comb begin
      result.major_opcode = opc;
      result.dest_reg     = instr_word[11:7];
      result.src1_reg     = instr_word[19:15];
      result.src2_reg     = instr_word[24:20];
      result.func3_field  = f3;
      result.func7_field  = instr_word[31:25];
      result.format_class = FMT_UNKNOWN;
      result.immediate    = '0;
      result.operation    = OP_UNKNOWN;
      case (opc)
         OPC_OP: begin
            result.format_class = FMT_R;
            result.operation    = r_op(f3, alt);
         end
         OPC_LOAD: begin
            result.format_class = FMT_I;
            result.immediate    = imm_i;
            result.operation    = load_op(f3);
         end
         OPC_OP_IMM: begin
            result.format_class = FMT_I;
            // Immediate shifts carry only the shift amount.
            result.immediate    = (f3 == F3_SL || f3 == F3_SR) ? shamt : imm_i;
            result.operation    = alui_op(f3, alt);
         end
         OPC_JALR: begin
            result.format_class = FMT_I;
            result.immediate    = imm_i;
            result.operation    = OP_JALR;
         end
         OPC_SYSTEM: begin
            result.format_class = FMT_I;
            result.immediate    = imm_i;
            result.operation    = (instr_word[31:20] == 12'd0) ? OP_ECALL : OP_EBREAK;
         end
         OPC_STORE: begin
            result.format_class = FMT_S;
            result.immediate    = imm_s;
            result.operation    = store_op(f3);
         end
         OPC_BRANCH: begin
            result.format_class = FMT_B;
            result.immediate    = imm_b;
            result.operation    = branch_op(f3);
         end
         OPC_LUI: begin
            result.format_class = FMT_U;
            result.immediate    = imm_u;
            result.operation    = OP_LUI;
         end
         OPC_AUIPC: begin
            result.format_class = FMT_U;
            result.immediate    = imm_u;
            result.operation    = OP_AUIPC;
         end
         OPC_JAL: begin
            result.format_class = FMT_J;
            result.immediate    = imm_j;
            result.operation    = OP_JAL;
         end
         default: begin
            result.format_class = FMT_UNKNOWN;
         end
      endcase
   end

endmodule

[rtl/rv32i_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// RV32I instruction decoder
// Registered decode of one instruction word per transaction.
// ----------------------------------------------------------------------------
// Each request transaction carries one 32-bit RV32I instruction word and
// produces exactly one response transaction with its opcode, register
// numbers, funct3/funct7, format class, sign-extended immediate and a dense
// operation number. The instruction is captured in an input register, decoded
// by a single pass of combinational field logic, and captured in a result
// register; a response is offered once its decode sits in the result register
// and is taken when the response side is ready. One instruction is
// accepted every cycle while the response side keeps up.
// When the response side stalls, the two registers fill and the request
// ready drops; nothing is lost or reordered. The block holds no state beyond
// these two pipeline registers.
module rv32i_instruction_decoder
   import rvd_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   rvd_req_if.sink   req_chan,
   rvd_rsp_if.source rsp_chan
);

`include "assert_macros.svh"

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [31:0]    instr_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   dec_result_type result_ff;
   dec_result_type dec_result;
   logic           out_advance;
   logic           in_advance;

   // Stage enables: a stage loads when it is empty or its contents move on.
   assign out_advance    = !out_valid_ff || rsp_chan.ready;
   assign in_advance     = !in_valid_ff || out_advance;
   assign req_chan.ready = in_advance;

   assign in_valid_in  = in_advance ? req_chan.valid : in_valid_ff;
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   // Valid flags of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register for the instruction word.
   always_ff @(posedge clock) begin
      if (in_advance) begin
         instr_ff <= req_chan.instr_word;
      end
   end

   rvd_decode u_decode (
      .instr_word (instr_ff),
      .result     (dec_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (out_advance) begin
         result_ff <= dec_result;
      end
   end

   // Response outputs.
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.major_opcode = result_ff.major_opcode;
   assign rsp_chan.dest_reg     = result_ff.dest_reg;
   assign rsp_chan.src1_reg     = result_ff.src1_reg;
   assign rsp_chan.src2_reg     = result_ff.src2_reg;
   assign rsp_chan.func3_field  = result_ff.func3_field;
   assign rsp_chan.func7_field  = result_ff.func7_field;
   assign rsp_chan.format_class = result_ff.format_class;
   assign rsp_chan.immediate    = result_ff.immediate;
   assign rsp_chan.operation    = result_ff.operation;

   // An accepted request always lands in the input stage.
   `ASSERT_NEXT(a_req_lands, clock, reset, req_chan.valid && req_chan.ready, in_valid_ff)
   // A full input stage moving on always produces a response.
   `ASSERT_NEXT(a_stage_moves, clock, reset, in_valid_ff && out_advance, rsp_chan.valid)
   // An empty input stage never refuses a request.
   `ASSERT_IMPL(a_ready_empty, clock, reset, !in_valid_ff, req_chan.ready)
   // Unknown format and unknown operation always go together.
   `ASSERT_IMPL(a_unknown_pair, clock, reset, rsp_chan.valid,
      (rsp_chan.format_class == FMT_UNKNOWN) == (rsp_chan.operation == OP_UNKNOWN))
   // Register-register instructions carry no immediate.
   `ASSERT_IMPL(a_r_no_imm, clock, reset, rsp_chan.valid && rsp_chan.format_class == FMT_R,
      rsp_chan.immediate == 32'sd0)

endmodule
